FILE: hw/rtl/masked_band_mean_zscore_core_defines.svh
// Assertion macros shared by the masked band mean z-score RTL.
// Users must have clk and rst_n in scope.
`ifndef MASKED_BAND_MEAN_ZSCORE_CORE_DEFINES_SVH
`define MASKED_BAND_MEAN_ZSCORE_CORE_DEFINES_SVH

// Same-cycle implication.
`define MBZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mbz_pkg.sv
// Package for the masked band mean z-score core: widths, codes, control structs
// and saturation helpers. No dependencies.
package mbz_pkg;

  localparam int MAX_BANDS_DEF = 64;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 32;
  localparam int MEAN_W        = 32;
  localparam int MSUM_W        = 38;
  localparam int NB_W          = 7;
  localparam int Z_W           = 24;
  localparam int ALU_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC_RD, ST_ACC_WR,
    ST_MEAN_RD, ST_MEAN_DIV, ST_MEAN_WAIT,
    ST_GM_DIV, ST_GM_WAIT,
    ST_VAR_RD, ST_VAR_MUL, ST_VAR_WAIT,
    ST_VDIV, ST_VDIV_WAIT, ST_NORM, ST_SQRT_WAIT,
    ST_EMIT_RD, ST_EMIT_DIV, ST_EMIT_WAIT, ST_OUT, ST_CLEAR
  } state_t;

  typedef enum logic [1:0] {ALU_DIV, ALU_MUL, ALU_SQRT} alu_op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_VOXEL = 2'd1,
    STAT_FLAT     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUE, CFG_MASK_EN, CFG_NUM_ROWS, CFG_NUM_COLS, CFG_NUM_BANDS
  } cfg_idx_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef struct packed {
    logic we;
    logic clr;
  } store_req_t;

  // Signed saturation of a quotient magnitude to a Q15.16 mean.
  function automatic logic [MEAN_W-1:0] mean_sat(input logic [ALU_W-1:0] q,
                                                 input logic neg);
    logic [MEAN_W-1:0] r;
    if (neg) begin
      if (q >= 64'h8000_0000) r = 32'h8000_0000;
      else r = -q[MEAN_W-1:0];
    end else begin
      if (q > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = q[MEAN_W-1:0];
    end
    return r;
  endfunction

  // Signed saturation of a quotient magnitude to a Q7.16 z-score.
  function automatic logic [Z_W-1:0] z_sat(input logic [ALU_W-1:0] q,
                                           input logic neg);
    logic [Z_W-1:0] r;
    if (neg) begin
      if (q >= 64'h80_0000) r = 24'h80_0000;
      else r = -q[Z_W-1:0];
    end else begin
      if (q > 64'h7F_FFFF) r = 24'h7F_FFFF;
      else r = q[Z_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/masked_band_mean_zscore_core.sv
// Masked band mean z-score core. A non-final sample item is accepted, then the
// store entry is read and the saturating add is written back. The final item
// starts normalization on the shared iterative unit: band means, global mean,
// squared deviations, variance, normalization and square root, then the n
// results are emitted (n = effective band count) and the store is cleared. With
// no counted voxel the flagged results are emitted directly; a zero variance
// skips normalization and the square root. Input is not ready during that work.
// Depends on mbz_pkg, mbz_alu, mbz_store and the assertion macro header.
`include "masked_band_mean_zscore_core_defines.svh"
module masked_band_mean_zscore_core #(
  parameter int MAX_BANDS = mbz_pkg::MAX_BANDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mbz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbz_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [9:0]                      in_row,
  input  logic [9:0]                      in_col,
  input  logic [5:0]                      in_band,
  input  logic signed [15:0]              in_sample,
  input  logic signed [15:0]              in_first_sample,
  input  logic                            in_mask_bit,
  input  logic                            in_slice_ok,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      out_band_index,
  output logic signed [23:0]              out_z_value,
  output logic                            out_last_result,
  output logic [1:0]                      out_status
);
  import mbz_pkg::*;

  localparam int IDX_W = $clog2(MAX_BANDS);

  // configuration
  logic signed [15:0] min_value_r;
  logic               mask_en_r;
  logic [10:0]        num_rows_r, num_cols_r;
  logic [NB_W-1:0]    num_bands_r;

  state_t state_r, state_nxt;

  logic [5:0]        band_r, band_nxt;
  logic signed [15:0] sample_r, sample_nxt;
  logic              cnt_en_r, cnt_en_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  voxel_cnt_r, voxel_cnt_nxt;
  logic [NB_W-1:0]   idx_r, idx_nxt;
  logic [MSUM_W-1:0] msum_r, msum_nxt;
  logic [MEAN_W-1:0] m_r, m_nxt;
  logic [ALU_W-1:0]  sq_r, sq_nxt;
  logic [ALU_W-1:0]  var_r, var_nxt;
  logic [5:0]        k_r, k_nxt;
  logic [31:0]       sigma_r, sigma_nxt;
  status_t           status_r, status_nxt;
  logic              neg_r, neg_nxt;
  logic [Z_W-1:0]    z_r, z_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_band_r, out_band_nxt;
  logic [Z_W-1:0]    out_z_r, out_z_nxt;
  logic              out_last_r, out_last_nxt;
  status_t           out_status_r, out_status_nxt;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;

  store_req_t       st_req;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  logic [SUM_W-1:0] st_wdata, st_rdata;

  // derived values
  logic [NB_W-1:0]   n_eff;
  logic              last_band;
  logic              counted;
  logic              cnt_inc;
  logic [CNT_W-1:0]  cnt_after;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W-1:0]  sum_mag;
  logic [MEAN_W-1:0] mean_q;
  logic [MEAN_W-1:0] mean_sat_q;
  logic [MEAN_W:0]   d;
  logic              d_neg;
  logic [MEAN_W:0]   ad;
  logic [MSUM_W-1:0] msum_mag;
  logic              norm_more;
  logic [5:0]        f;
  logic [5:0]        shamt;
  logic              ovf;
  logic              out_free;

  always_comb begin
    if (num_bands_r > NB_W'(MAX_BANDS)) n_eff = NB_W'(MAX_BANDS);
    else if (num_bands_r < 7'd2)        n_eff = 7'd2;
    else                                n_eff = num_bands_r;
    last_band = (idx_r == n_eff - 7'd1);

    counted = (in_row != '0) && ({2'b00, in_row} + 12'd2 <= {1'b0, num_rows_r}) &&
              (in_col != '0) && ({2'b00, in_col} + 12'd2 <= {1'b0, num_cols_r}) &&
              in_slice_ok && (in_first_sample >= min_value_r) &&
              (!mask_en_r || in_mask_bit) && ({1'b0, in_band} < n_eff);

    cnt_inc   = cnt_en_r && (band_r == '0) && (voxel_cnt_r != '1);
    cnt_after = voxel_cnt_r + {{(CNT_W-1){1'b0}}, cnt_inc};

    // saturating 48-bit accumulate
    sum_ext = {st_rdata[SUM_W-1], st_rdata} + {{(SUM_W-15){sample_r[15]}}, sample_r};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_sat = sum_ext[SUM_W-1:0];
    sum_mag = st_rdata[SUM_W-1] ? -st_rdata : st_rdata;

    mean_sat_q = mean_sat(alu_res, neg_r);

    mean_q = st_rdata[MEAN_W-1:0];
    d      = {mean_q[MEAN_W-1], mean_q} - {m_r[MEAN_W-1], m_r};
    d_neg  = d[MEAN_W];
    ad     = d_neg ? -d : d;

    msum_mag = msum_r[MSUM_W-1] ? -msum_r : msum_r;

    norm_more = (k_r < 6'd62) && (var_r[63:62] == 2'b00);
    f         = 6'd13 + {1'b0, k_r[5:1]};
    shamt     = 6'd0 - f;                 // 64 - f, held in 6 bits
    ovf       = |(ad >> shamt);

    out_free = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_ACC_RD;
      ST_ACC_RD:    state_nxt = ST_ACC_WR;
      ST_ACC_WR: begin
        if (!last_r)             state_nxt = ST_IDLE;
        else if (cnt_after == '0) state_nxt = ST_EMIT_RD;
        else                     state_nxt = ST_MEAN_RD;
      end
      ST_MEAN_RD:   state_nxt = ST_MEAN_DIV;
      ST_MEAN_DIV:  state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (alu_rsp.done) state_nxt = last_band ? ST_GM_DIV : ST_MEAN_RD;
      ST_GM_DIV:    state_nxt = ST_GM_WAIT;
      ST_GM_WAIT:   if (alu_rsp.done) state_nxt = ST_VAR_RD;
      ST_VAR_RD:    state_nxt = ST_VAR_MUL;
      ST_VAR_MUL:   state_nxt = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (alu_rsp.done) state_nxt = last_band ? ST_VDIV : ST_VAR_RD;
      ST_VDIV:      state_nxt = ST_VDIV_WAIT;
      ST_VDIV_WAIT: if (alu_rsp.done) state_nxt = (alu_res == '0) ? ST_EMIT_RD : ST_NORM;
      ST_NORM:      if (!norm_more) state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (alu_rsp.done) state_nxt = ST_EMIT_RD;
      ST_EMIT_RD:   state_nxt = ST_EMIT_DIV;
      ST_EMIT_DIV:  state_nxt = (status_r != STAT_OK || ovf) ? ST_OUT : ST_EMIT_WAIT;
      ST_EMIT_WAIT: if (alu_rsp.done) state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = last_band ? ST_CLEAR : ST_EMIT_RD;
      ST_CLEAR:     state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    band_nxt      = band_r;
    sample_nxt    = sample_r;
    cnt_en_nxt    = cnt_en_r;
    last_nxt      = last_r;
    voxel_cnt_nxt = voxel_cnt_r;
    idx_nxt       = idx_r;
    msum_nxt      = msum_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    var_nxt       = var_r;
    k_nxt         = k_r;
    sigma_nxt     = sigma_r;
    status_nxt    = status_r;
    neg_nxt       = neg_r;
    z_nxt         = z_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_band_nxt   = out_band_r;
    out_z_nxt      = out_z_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    alu_req  = '{start: 1'b0, op: ALU_DIV};
    alu_a    = '0;
    alu_b    = '0;
    st_req   = '0;
    st_waddr = idx_r[IDX_W-1:0];
    st_wdata = '0;
    st_raddr = (state_r == ST_ACC_RD) ? band_r[IDX_W-1:0] : idx_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          band_nxt   = in_band;
          sample_nxt = in_sample;
          cnt_en_nxt = counted;
          last_nxt   = in_last;
        end
      end
      ST_ACC_WR: begin
        if (cnt_en_r) begin
          st_req.we = 1'b1;
          st_waddr  = band_r[IDX_W-1:0];
          st_wdata  = sum_sat;
        end
        voxel_cnt_nxt = cnt_after;
        if (last_r) begin
          idx_nxt  = '0;
          msum_nxt = '0;
          if (cnt_after == '0) status_nxt = STAT_NO_VOXEL;
        end
      end
      ST_MEAN_DIV: begin
        alu_req = '{start: 1'b1, op: ALU_DIV};
        alu_a   = {sum_mag, 16'd0};
        alu_b   = {32'd0, voxel_cnt_r};
        neg_nxt = st_rdata[SUM_W-1];
      end
      ST_MEAN_WAIT: begin
        if (alu_rsp.done) begin
          st_req.we = 1'b1;
          st_wdata  = {{(SUM_W-MEAN_W){mean_sat_q[MEAN_W-1]}}, mean_sat_q};
          msum_nxt  = msum_r + {{(MSUM_W-MEAN_W){mean_sat_q[MEAN_W-1]}}, mean_sat_q};
          if (!last_band) idx_nxt = idx_r + 7'd1;
        end
      end
      ST_GM_DIV: begin
        alu_req = '{start: 1'b1, op: ALU_DIV};
        alu_a   = {{(ALU_W-MSUM_W){1'b0}}, msum_mag};
        alu_b   = {{(ALU_W-NB_W){1'b0}}, n_eff};
        neg_nxt = msum_r[MSUM_W-1];
      end
      ST_GM_WAIT: begin
        if (alu_rsp.done) begin
          m_nxt   = neg_r ? -alu_res[MEAN_W-1:0] : alu_res[MEAN_W-1:0];
          idx_nxt = '0;
          sq_nxt  = '0;
        end
      end
      ST_VAR_MUL: begin
        alu_req = '{start: 1'b1, op: ALU_MUL};
        alu_a   = {{(ALU_W-MEAN_W-1){1'b0}}, ad};
        alu_b   = {{(ALU_W-MEAN_W-1){1'b0}}, ad};
      end
      ST_VAR_WAIT: begin
        if (alu_rsp.done) begin
          sq_nxt = sq_r + (alu_res >> 6);
          if (!last_band) idx_nxt = idx_r + 7'd1;
        end
      end
      ST_VDIV: begin
        alu_req = '{start: 1'b1, op: ALU_DIV};
        alu_a   = sq_r;
        alu_b   = {{(ALU_W-NB_W){1'b0}}, n_eff - 7'd1};
      end
      ST_VDIV_WAIT: begin
        if (alu_rsp.done) begin
          var_nxt = alu_res;
          k_nxt   = '0;
          idx_nxt = '0;
          if (alu_res == '0) status_nxt = STAT_FLAT;
        end
      end
      ST_NORM: begin
        // shift by two until the top pair is occupied or k reaches 62
        if (norm_more) begin
          var_nxt = {var_r[61:0], 2'b00};
          k_nxt   = k_r + 6'd2;
        end else begin
          alu_req = '{start: 1'b1, op: ALU_SQRT};
          alu_a   = var_r;
        end
      end
      ST_SQRT_WAIT: begin
        if (alu_rsp.done) sigma_nxt = alu_res[31:0];
      end
      ST_EMIT_DIV: begin
        neg_nxt = d_neg;
        if (status_r != STAT_OK) begin
          z_nxt = '0;
        end else if (ovf) begin
          z_nxt = z_sat('1, d_neg);
        end else begin
          alu_req = '{start: 1'b1, op: ALU_DIV};
          alu_a   = {{(ALU_W-MEAN_W-1){1'b0}}, ad} << f;
          alu_b   = {32'd0, sigma_r};
        end
      end
      ST_EMIT_WAIT: begin
        if (alu_rsp.done) z_nxt = z_sat(alu_res, neg_r);
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_band_nxt   = idx_r[5:0];
          out_z_nxt      = z_r;
          out_last_nxt   = last_band;
          out_status_nxt = status_r;
          if (!last_band) idx_nxt = idx_r + 7'd1;
        end
      end
      ST_CLEAR: begin
        st_req.clr    = 1'b1;
        voxel_cnt_nxt = '0;
        status_nxt    = STAT_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= '0;
      mask_en_r   <= 1'b0;
      num_rows_r  <= 11'd64;
      num_cols_r  <= 11'd64;
      num_bands_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_VALUE: min_value_r <= cfg_wdata;
        CFG_MASK_EN:   mask_en_r   <= cfg_wdata[0];
        CFG_NUM_ROWS:  num_rows_r  <= cfg_wdata[10:0];
        CFG_NUM_COLS:  num_cols_r  <= cfg_wdata[10:0];
        CFG_NUM_BANDS: num_bands_r <= cfg_wdata[NB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      voxel_cnt_r <= '0;
      status_r    <= STAT_OK;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      voxel_cnt_r <= voxel_cnt_nxt;
      status_r    <= status_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    band_r       <= band_nxt;
    sample_r     <= sample_nxt;
    cnt_en_r     <= cnt_en_nxt;
    last_r       <= last_nxt;
    msum_r       <= msum_nxt;
    m_r          <= m_nxt;
    sq_r         <= sq_nxt;
    var_r        <= var_nxt;
    k_r          <= k_nxt;
    sigma_r      <= sigma_nxt;
    neg_r        <= neg_nxt;
    z_r          <= z_nxt;
    out_band_r   <= out_band_nxt;
    out_z_r      <= out_z_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  mbz_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

  mbz_store #(.MAX_BANDS(MAX_BANDS), .IDX_W(IDX_W)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_band_index  = out_band_r;
  assign out_z_value     = out_z_r;
  assign out_last_result = out_last_r;
  assign out_status      = out_status_r;

  `MBZ_ASSERT_NOW(a_ready_unit_idle, in_ready, !alu_rsp.busy, "item taken while unit busy")
  `MBZ_ASSERT_NOW(a_start_when_idle, alu_req.start, !alu_rsp.busy, "unit restarted while busy")
  `MBZ_ASSERT_NEXT(a_clear_count, state_r == ST_CLEAR, voxel_cnt_r == '0, "count not cleared")
  `MBZ_ASSERT_NOW(a_flag_zero_z, out_valid_r && (out_status_r != STAT_OK), out_z_r == '0,
                  "flagged result with nonzero z")

endmodule

FILE: hw/rtl/mbz_alu.sv
// Shared iterative arithmetic unit: 64/64 restoring divide, 64-bit shift-add
// multiply and 64-bit integer square root, one step per cycle. Uses mbz_pkg.
module mbz_alu (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbz_pkg::alu_req_t       req,
  input  logic [mbz_pkg::ALU_W-1:0] a,
  input  logic [mbz_pkg::ALU_W-1:0] b,
  output mbz_pkg::alu_rsp_t       rsp,
  output logic [mbz_pkg::ALU_W-1:0] res
);
  import mbz_pkg::*;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  alu_op_t         op_r, op_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic [65:0]     acc_r, acc_nxt;
  logic [ALU_W-1:0] quo_r, quo_nxt;
  logic [ALU_W-1:0] b_r, b_nxt;
  logic [31:0]     root_r, root_nxt;

  logic [64:0] div_t;
  logic        div_ge;
  logic [65:0] sq_t;
  logic [65:0] sq_trial;
  logic        sq_ge;
  logic [6:0]  last_step;

  always_comb begin
    div_t    = {acc_r[63:0], quo_r[63]};
    div_ge   = div_t >= {1'b0, b_r};
    sq_t     = {acc_r[63:0], quo_r[63:62]};
    sq_trial = {32'd0, root_r, 2'b01};
    sq_ge    = sq_t >= sq_trial;
    last_step = (op_r == ALU_SQRT) ? 7'd31 : 7'd63;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    b_nxt    = b_r;
    root_nxt = root_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      quo_nxt  = a;
      b_nxt    = b;
      root_nxt = '0;
    end else if (busy_r) begin
      case (op_r)
        ALU_DIV: begin
          acc_nxt = div_ge ? {1'b0, div_t - {1'b0, b_r}} : {1'b0, div_t};
          quo_nxt = {quo_r[62:0], div_ge};
        end
        ALU_MUL: begin
          acc_nxt = {2'b00, {acc_r[62:0], 1'b0} + (quo_r[63] ? b_r : '0)};
          quo_nxt = {quo_r[62:0], 1'b0};
        end
        ALU_SQRT: begin
          acc_nxt  = sq_ge ? sq_t - sq_trial : sq_t;
          root_nxt = {root_r[30:0], sq_ge};
          quo_nxt  = {quo_r[61:0], 2'b00};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    quo_r  <= quo_nxt;
    b_r    <= b_nxt;
    root_r <= root_nxt;
  end

  always_comb begin
    case (op_r)
      ALU_DIV:  res = quo_r;
      ALU_MUL:  res = acc_r[63:0];
      ALU_SQRT: res = {32'd0, root_r};
      default:  res = quo_r;
    endcase
    rsp.busy = busy_r;
    rsp.done = done_r;
  end

endmodule

FILE: hw/rtl/mbz_store.sv
// Per-band store: sums during accumulation, then band means. Entry valid bits
// make unwritten entries read as zero. Uses mbz_pkg.
module mbz_store #(
  parameter int MAX_BANDS = mbz_pkg::MAX_BANDS_DEF,
  parameter int IDX_W     = $clog2(MAX_BANDS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mbz_pkg::store_req_t       req,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [mbz_pkg::SUM_W-1:0] wdata,
  input  logic [IDX_W-1:0]          raddr,
  output logic [mbz_pkg::SUM_W-1:0] rdata
);
  import mbz_pkg::*;

  logic [SUM_W-1:0]     mem [MAX_BANDS];
  logic [MAX_BANDS-1:0] valid_r;
  logic [SUM_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= valid_r[raddr];
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule
